// File: rtl/dre_pkg.sv
// Shared types and constants for the digit run date extractor.
`default_nettype none

package dre_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int MD_W    = 7;  // width of month/day accumulators
    localparam int RUN_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 14;
    localparam int OUT_W   = 24;

    localparam logic [CHAR_W-1:0]  DIGIT_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0]  DIGIT_NINE = 8'd57;
    localparam logic [YEAR_W-1:0]  MIN_YEAR   = 14'd2000;
    localparam logic [MD_W-1:0]    MAX_MONTH  = 7'd12;
    localparam logic [MD_W-1:0]    MAX_DAY    = 7'd31;
    localparam logic [RUN_W-1:0]   RUN_DATE   = 4'd8;
    localparam logic [RUN_W-1:0]   RUN_SAT    = 4'd9;
    localparam logic [RUN_W-1:0]   RUN_MONTH  = 4'd4;
    localparam logic [RUN_W-1:0]   RUN_DAY    = 4'd6;

    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TODAY_YEAR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_TODAY_DAY   = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } today_t;

    typedef struct packed {
        logic               found;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/dre_cfg_regs.sv
// Configuration registers holding the current date.
`default_nettype none

module dre_cfg_regs (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic [dre_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [dre_pkg::CFG_W-1:0] cfg_data,
    output dre_pkg::today_t                today
);

    dre_pkg::today_t today_reg;
    dre_pkg::today_t today_next;

    always_comb begin
        today_next = today_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                dre_pkg::REG_TODAY_YEAR:  today_next.year  = cfg_data[dre_pkg::YEAR_W-1:0];
                dre_pkg::REG_TODAY_MONTH: today_next.month = cfg_data[dre_pkg::MONTH_W-1:0];
                dre_pkg::REG_TODAY_DAY:   today_next.day   = cfg_data[dre_pkg::DAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            today_reg.year  <= dre_pkg::RESET_YEAR;
            today_reg.month <= dre_pkg::RESET_MONTH;
            today_reg.day   <= dre_pkg::RESET_DAY;
        end else begin
            today_reg <= today_next;
        end
    end

    assign today = today_reg;

endmodule

`default_nettype wire

// File: rtl/dre_scan.sv
// Per-byte run tracking, date check and per-name latch.
`default_nettype none

module dre_scan (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic [dre_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       is_final,
    input  wire dre_pkg::today_t            today,
    output dre_pkg::result_t                result
);

    logic [dre_pkg::RUN_W-1:0]   run_length_reg, run_length_next;
    logic [dre_pkg::YEAR_W-1:0]  year_digits_reg, year_digits_next;
    logic [dre_pkg::MD_W-1:0]    month_digits_reg, month_digits_next;
    logic [dre_pkg::MD_W-1:0]    day_digits_reg, day_digits_next;
    logic                        date_latched_reg, date_latched_next;
    logic [dre_pkg::YEAR_W-1:0]  latched_year_reg, latched_year_next;
    logic [dre_pkg::MONTH_W-1:0] latched_month_reg, latched_month_next;

    logic                        is_digit;
    logic [3:0]                  digit;
    logic [17:0]                 year_acc;
    logic [10:0]                 month_acc;
    logic [10:0]                 day_acc;
    logic [dre_pkg::RUN_W-1:0]   t_run;
    logic [dre_pkg::YEAR_W-1:0]  t_year;
    logic [dre_pkg::MD_W-1:0]    t_month;
    logic [dre_pkg::MD_W-1:0]    t_day;
    logic [dre_pkg::MD_W-1:0]    today_month_x;
    logic [dre_pkg::MD_W-1:0]    today_day_x;
    logic                        close;
    logic                        sane;
    logic                        past;
    logic                        take_date;

    assign is_digit = (char_code >= dre_pkg::DIGIT_ZERO) && (char_code <= dre_pkg::DIGIT_NINE);
    assign digit    = char_code[3:0];  // '0'..'9' map to low nibble 0..9

    // x*10 + d as (x<<3) + (x<<1) + d
    assign year_acc  = {year_digits_reg, 3'b000} + {3'b000, year_digits_reg, 1'b0}
                     + {14'd0, digit};
    assign month_acc = {month_digits_reg, 3'b000} + {3'b000, month_digits_reg, 1'b0}
                     + {7'd0, digit};
    assign day_acc   = {day_digits_reg, 3'b000} + {3'b000, day_digits_reg, 1'b0}
                     + {7'd0, digit};

    // run after taking this byte's digit (unchanged for a non-digit)
    always_comb begin
        t_run   = run_length_reg;
        t_year  = year_digits_reg;
        t_month = month_digits_reg;
        t_day   = day_digits_reg;
        if (is_digit) begin
            if (run_length_reg < dre_pkg::RUN_MONTH) begin
                t_year = year_acc[dre_pkg::YEAR_W-1:0];
            end else if (run_length_reg < dre_pkg::RUN_DAY) begin
                t_month = month_acc[dre_pkg::MD_W-1:0];
            end else if (run_length_reg < dre_pkg::RUN_DATE) begin
                t_day = day_acc[dre_pkg::MD_W-1:0];
            end
            if (run_length_reg < dre_pkg::RUN_SAT) begin
                t_run = run_length_reg + 4'd1;
            end
        end
    end

    assign today_month_x = {3'b000, today.month};
    assign today_day_x   = {2'b00, today.day};

    assign close = !is_digit || is_final;
    assign sane  = (t_year >= dre_pkg::MIN_YEAR) && (t_month != '0)
                && (t_month <= dre_pkg::MAX_MONTH) && (t_day != '0)
                && (t_day <= dre_pkg::MAX_DAY);
    assign past  = (t_year < today.year)
                || ((t_year == today.year) && ((t_month < today_month_x)
                    || ((t_month == today_month_x) && (t_day <= today_day_x))));
    assign take_date = close && !date_latched_reg && (t_run == dre_pkg::RUN_DATE)
                    && sane && past;

    always_comb begin
        date_latched_next  = date_latched_reg;
        latched_year_next  = latched_year_reg;
        latched_month_next = latched_month_reg;
        if (take_date) begin
            date_latched_next  = 1'b1;
            latched_year_next  = t_year;
            latched_month_next = t_month[dre_pkg::MONTH_W-1:0];
        end

        result.found = date_latched_next;
        result.year  = date_latched_next ? latched_year_next  : '0;
        result.month = date_latched_next ? latched_month_next : '0;

        run_length_next   = close ? '0 : t_run;
        year_digits_next  = close ? '0 : t_year;
        month_digits_next = close ? '0 : t_month;
        day_digits_next   = close ? '0 : t_day;

        // end of name starts a fresh one
        if (is_final) begin
            date_latched_next  = 1'b0;
            latched_year_next  = '0;
            latched_month_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_length_reg    <= '0;
            year_digits_reg   <= '0;
            month_digits_reg  <= '0;
            day_digits_reg    <= '0;
            date_latched_reg  <= 1'b0;
            latched_year_reg  <= '0;
            latched_month_reg <= '0;
        end else if (advance) begin
            run_length_reg    <= run_length_next;
            year_digits_reg   <= year_digits_next;
            month_digits_reg  <= month_digits_next;
            day_digits_reg    <= day_digits_next;
            date_latched_reg  <= date_latched_next;
            latched_year_reg  <= latched_year_next;
            latched_month_reg <= latched_month_next;
        end
    end

    a_run_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        run_length_reg <= dre_pkg::RUN_SAT)
        else $error("run counter beyond saturation");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_final) |=> (run_length_reg == '0 && !date_latched_reg))
        else $error("state not cleared after end of name");

    a_latched_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        date_latched_reg |-> (latched_year_reg >= dre_pkg::MIN_YEAR
                              && latched_month_reg != '0 && latched_month_reg <= 4'd12))
        else $error("latched date out of range");

    a_no_relatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && date_latched_reg && !is_final) |=> $stable(latched_year_reg))
        else $error("first date overwritten");

endmodule

`default_nettype wire

// File: rtl/digit_run_date_extractor.sv
// Top level: finds the first valid YYYYMMDD digit run in a byte-serial name.
//
// Usage: the name arrives one byte per word on the s_ channel, s_tlast on its
// last byte. On that last byte exactly one word leaves on the m_ channel:
// found flag, year and month of the first accepted date, or zeros.
// The current date is set through the cfg_ write channel (index 0 year,
// 1 month, 2 day); it is always ready and should be written while idle.
// Path: a byte is registered in the input register on acceptance and scanned from
// there; the result word is registered in the output register from that scan.
// Throughput: one byte per cycle unless a final byte waits for the output register;
// each byte updates the run state between the input register and the state registers.
// Reset (aresetn low, synchronous) empties both registers, clears the run
// and latch state and loads the current date 2000-01-01.
// When the receiver stalls, the result word holds in the output register;
// non-final bytes keep being accepted, and a final byte waits in the input
// register until the output register frees, which then backs up s_tready.
`default_nettype none

module digit_run_date_extractor (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] char_code
    input  wire logic                       s_tlast,   // is_final
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [dre_pkg::OUT_W-1:0]       m_tdata,   // [0] found, [14:1] found_year,
                                                       // [18:15] found_month, rest 0
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [dre_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [dre_pkg::CFG_W-1:0]  cfg_data
);

    logic                       in_valid_reg;
    logic [dre_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    dre_pkg::result_t           out_reg;
    logic                       advance;
    dre_pkg::today_t            today;
    dre_pkg::result_t           result;

    assign cfg_ready = 1'b1;

    dre_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .today     (today)
    );

    // only a final byte needs room in the output register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dre_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .char_code (in_char_reg),
        .is_final  (in_last_reg),
        .today     (today),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.month, out_reg.year, out_reg.found};

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for digit_run_date_extractor: random and directed names, date predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HALF_BYTES    = 33;
    localparam int NUM_PHASES    = 8;

    typedef struct {
        logic [dre_pkg::CHAR_W-1:0] code;
        logic                       last;
    } name_byte_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [dre_pkg::CHAR_W-1:0]   s_tdata   = '0;
    logic                         s_tlast   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [dre_pkg::OUT_W-1:0]    m_tdata;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [dre_pkg::IDX_W-1:0]    cfg_index = dre_pkg::REG_TODAY_YEAR;
    logic [dre_pkg::CFG_W-1:0]    cfg_data  = '0;

    name_byte_t                 pending_bytes[$];
    logic [dre_pkg::CHAR_W-1:0] name_bytes[$];
    dre_pkg::result_t           expected_dates[$];
    dre_pkg::result_t           want_date;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_queued   = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // current date as the block should hold it
    logic [dre_pkg::YEAR_W-1:0]  now_year  = dre_pkg::RESET_YEAR;
    logic [dre_pkg::MONTH_W-1:0] now_month = dre_pkg::RESET_MONTH;
    logic [dre_pkg::DAY_W-1:0]   now_day   = dre_pkg::RESET_DAY;

    // per-name scan state
    logic [dre_pkg::RUN_W-1:0]   run_len    = '0;
    logic [dre_pkg::YEAR_W-1:0]  acc_year   = '0;
    logic [dre_pkg::MD_W-1:0]    acc_month  = '0;
    logic [dre_pkg::MD_W-1:0]    acc_day    = '0;
    logic                        have_date  = 1'b0;
    logic [dre_pkg::YEAR_W-1:0]  date_year  = '0;
    logic [dre_pkg::MONTH_W-1:0] date_month = '0;

    digit_run_date_extractor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    task clear_digit_run();
        run_len   = '0;
        acc_year  = '0;
        acc_month = '0;
        acc_day   = '0;
    endtask

    task close_digit_run();
        logic sane;
        logic not_future;
        if (!have_date && run_len == dre_pkg::RUN_DATE) begin
            sane = acc_year >= dre_pkg::MIN_YEAR && acc_month >= 1
                   && acc_month <= dre_pkg::MAX_MONTH
                   && acc_day >= 1 && acc_day <= dre_pkg::MAX_DAY;
            not_future = acc_year < now_year ||
                         (acc_year == now_year && (acc_month < now_month ||
                          (acc_month == now_month && acc_day <= now_day)));
            if (sane && not_future) begin
                have_date  = 1'b1;
                date_year  = acc_year;
                date_month = acc_month[dre_pkg::MONTH_W-1:0];
            end
        end
        clear_digit_run();
    endtask

    task scan_name_byte(input logic [dre_pkg::CHAR_W-1:0] code, input logic last);
        logic [3:0]       digit;
        dre_pkg::result_t res;
        if (code >= dre_pkg::DIGIT_ZERO && code <= dre_pkg::DIGIT_NINE) begin
            digit = 4'(code - dre_pkg::DIGIT_ZERO);
            if (run_len < dre_pkg::RUN_MONTH)
                acc_year = acc_year * 14'd10 + dre_pkg::YEAR_W'(digit);
            else if (run_len < dre_pkg::RUN_DAY)
                acc_month = acc_month * 7'd10 + dre_pkg::MD_W'(digit);
            else if (run_len < dre_pkg::RUN_DATE)
                acc_day = acc_day * 7'd10 + dre_pkg::MD_W'(digit);
            if (run_len < dre_pkg::RUN_SAT)
                run_len = run_len + 1'b1;
        end else begin
            close_digit_run();
        end
        if (last) begin
            close_digit_run();
            res.found = have_date;
            res.year  = have_date ? date_year : '0;
            res.month = have_date ? date_month : '0;
            expected_dates.push_back(res);
            have_date  = 1'b0;
            date_year  = '0;
            date_month = '0;
        end
    endtask

    task report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // ---------------- driver, receiver, monitor ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].code;
                s_tlast  <= pending_bytes[0].last;
                void'(pending_bytes.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            // compare before predicting so a word leaving in the same cycle as its last byte cannot match itself
            if (m_tvalid && m_tready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result word with none pending, word", m_tdata, 0);
                end else begin
                    want_date = expected_dates.pop_front();
                    if (m_tdata[0] !== want_date.found)
                        report_mismatch("found", m_tdata[0], want_date.found);
                    if (m_tdata[14:1] !== want_date.year)
                        report_mismatch("found_year", m_tdata[14:1], want_date.year);
                    if (m_tdata[18:15] !== want_date.month)
                        report_mismatch("found_month", m_tdata[18:15], want_date.month);
                    if (m_tdata[dre_pkg::OUT_W-1:19] !== '0)
                        report_mismatch("padding", m_tdata[dre_pkg::OUT_W-1:19], 0);
                end
            end
            if (s_tvalid && s_tready)
                scan_name_byte(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dre_pkg::REG_TODAY_YEAR:  now_year  = cfg_data[dre_pkg::YEAR_W-1:0];
                    dre_pkg::REG_TODAY_MONTH: now_month = cfg_data[dre_pkg::MONTH_W-1:0];
                    dre_pkg::REG_TODAY_DAY:   now_day   = cfg_data[dre_pkg::DAY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task finish_name();
        name_byte_t item;
        foreach (name_bytes[i]) begin
            item.code = name_bytes[i];
            item.last = (i == name_bytes.size() - 1);
            pending_bytes.push_back(item);
        end
        bytes_queued += name_bytes.size();
        name_bytes.delete();
    endtask

    task automatic add_number(input int value, input int digits);
        int div;
        div = 1;
        repeat (digits - 1) div *= 10;
        repeat (digits) begin
            name_bytes.push_back(dre_pkg::DIGIT_ZERO + dre_pkg::CHAR_W'((value / div) % 10));
            div /= 10;
        end
    endtask

    task automatic add_digits(input int count);
        repeat (count)
            name_bytes.push_back(dre_pkg::DIGIT_ZERO + dre_pkg::CHAR_W'($urandom_range(9)));
    endtask

    function automatic logic [dre_pkg::CHAR_W-1:0] non_digit();
        logic [dre_pkg::CHAR_W-1:0] c;
        c = dre_pkg::CHAR_W'($urandom_range(255));
        while (c >= dre_pkg::DIGIT_ZERO && c <= dre_pkg::DIGIT_NINE)
            c = dre_pkg::CHAR_W'($urandom_range(255));
        return c;
    endfunction

    // dates cluster around the current date so that the comparison edges get hit
    function automatic int pick_year();
        int y;
        case ($urandom_range(7))
            0: y = int'(now_year);
            1: y = int'(now_year) - 1;
            2: y = int'(now_year) + 1;
            3: y = int'(dre_pkg::MIN_YEAR);
            4: y = int'(dre_pkg::MIN_YEAR) - 1;
            5: y = $urandom_range(2000, 2099);
            6: y = $urandom_range(9999);
            default: y = 9999;
        endcase
        if (y < 0)
            y = 0;
        return y % 10000;
    endfunction

    function automatic int pick_md(input int now_val, input int top);
        int v;
        case ($urandom_range(5))
            0: v = now_val;
            1: v = now_val - 1;
            2: v = now_val + 1;
            3: v = $urandom_range(1, top);
            4: v = $urandom_range(0, top + 1);
            default: v = $urandom_range(99);
        endcase
        if (v < 0)
            v = 0;
        return v % 100;
    endfunction

    task automatic add_date();
        add_number(pick_year(), 4);
        add_number(pick_md(int'(now_month), int'(dre_pkg::MAX_MONTH)), 2);
        add_number(pick_md(int'(now_day), int'(dre_pkg::MAX_DAY)), 2);
    endtask

    task automatic make_random_name();
        int shape;
        shape = $urandom_range(9);
        if (shape <= 5) begin
            repeat ($urandom_range(4))
                name_bytes.push_back(dre_pkg::CHAR_W'($urandom_range(97, 122)));
            add_date();
            if ($urandom_range(5) == 0)
                add_digits(1);  // nine digits: never a date
            case ($urandom_range(3))
                0: ;  // name ends on the last date digit
                1: begin
                    name_bytes.push_back(non_digit());
                    add_date();
                end
                2: begin
                    name_bytes.push_back(non_digit());
                    add_digits($urandom_range(1, 6));
                end
                default: begin
                    name_bytes.push_back(8'd46);
                    repeat (3) name_bytes.push_back(dre_pkg::CHAR_W'($urandom_range(97, 122)));
                end
            endcase
        end else if (shape <= 7) begin
            repeat ($urandom_range(1, 4)) begin
                add_digits($urandom_range(1, 12));
                if ($urandom_range(1))
                    name_bytes.push_back(non_digit());
            end
        end else begin
            repeat ($urandom_range(1, 8))
                name_bytes.push_back(dre_pkg::CHAR_W'($urandom_range(255)));
        end
        finish_name();
    endtask

    // sender holds off until every result is back and the pipeline is empty
    task drain();
        while (pending_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_today(input int y, input int m, input int d);
        logic [dre_pkg::IDX_W-1:0] regs[3];
        logic [dre_pkg::CFG_W-1:0] vals[3];
        regs = '{dre_pkg::REG_TODAY_YEAR, dre_pkg::REG_TODAY_MONTH, dre_pkg::REG_TODAY_DAY};
        vals = '{dre_pkg::CFG_W'(y), dre_pkg::CFG_W'(m), dre_pkg::CFG_W'(d)};
        @(posedge aclk);
        for (int r = 0; r < 3; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_year[NUM_PHASES]  = '{2024, 0, 9999, 16383, 2001, 2023, 2015, 2000};
        int phase_month[NUM_PHASES] = '{6, 1, 12, 15, 0, 12, 2, 1};
        int phase_day[NUM_PHASES]   = '{15, 1, 31, 31, 0, 31, 28, 1};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed names under the reset date 2000-01-01
        add_number(2000, 4);
        add_number(101, 4);           // ends on a digit, equal to today
        finish_name();
        name_bytes.push_back(8'hFF);  // single-byte name
        finish_name();
        add_number(20000101, 8);
        add_digits(1);                // nine-digit run
        name_bytes.push_back(8'h00);
        finish_name();
        name_bytes.push_back(8'd47);  // neighbors of the digit range
        name_bytes.push_back(8'd58);
        name_bytes.push_back(dre_pkg::DIGIT_ZERO);
        name_bytes.push_back(dre_pkg::DIGIT_NINE);
        name_bytes.push_back(8'h80);
        finish_name();
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_today(phase_year[p], phase_month[p], phase_day[p]);
            repeat (2) @(posedge aclk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (2) begin
                bytes_queued = 0;
                while (bytes_queued < HALF_BYTES) make_random_name();
                drain();
            end
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/dre_pkg.sv
rtl/dre_cfg_regs.sv
rtl/dre_scan.sv
rtl/digit_run_date_extractor.sv
test/testbench.sv
